[sv/zksr_pkg.sv]
`timescale 1ns / 1ps
// zksr_pkg: shared types, codes and constants of the zone keyed store node
// no dependencies

package zksr_pkg;

    localparam int COORD_W         = 17;
    localparam int WORD_W          = 32;
    localparam int ID_W            = 8;
    localparam int FILL_W          = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 17;
    localparam int STORE_DEPTH_DEF = 16;
    localparam int PEER_DEPTH_DEF  = 16;

    typedef logic [COORD_W-1:0] t_coord;

    // 1024.0 in 11.6 fixed point
    localparam t_coord COORD_FULL = 17'h10000;
    localparam t_coord COORD_ZERO = 17'h00000;

    typedef enum logic [1:0] {
        FN_ADD,
        FN_SEARCH,
        FN_DELETE,
        FN_ADD_PEER
    } t_func;

    typedef enum logic [1:0] {
        ST_LOCAL,
        ST_FORWARD,
        ST_OUTSIDE,
        ST_NO_ROUTE
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHOLE_RA,
        CFG_WHOLE_CA,
        CFG_WHOLE_RB,
        CFG_WHOLE_CB,
        CFG_OWN_RA,
        CFG_OWN_CA,
        CFG_OWN_RB,
        CFG_OWN_CB
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_PEER,
        S_WHOLE,
        S_OWN,
        S_PSCAN,
        S_SSCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_coord ra;
        t_coord ca;
        t_coord rb;
        t_coord cb;
    } t_rect;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_point;

    typedef struct packed {
        t_coord              row;
        t_coord              col;
        logic [WORD_W-1:0]   word;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_rect           zone;
    } t_peer;

    typedef struct packed {
        t_func             func;
        t_coord            point_row;
        t_coord            point_col;
        logic [WORD_W-1:0] data_word;
        logic [ID_W-1:0]   peer_id;
        t_coord            peer_row_a;
        t_coord            peer_col_a;
        t_coord            peer_row_b;
        t_coord            peer_col_b;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic              hit;
        logic [WORD_W-1:0] read_word;
        logic [ID_W-1:0]   forward_to;
        logic [FILL_W-1:0] fill_level;
    } t_out;

endpackage

[sv/zksr_ram.sv]
`timescale 1ns / 1ps
// zksr_ram: generic single write port, single read port ram with registered read
// no dependencies

module zksr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/zksr_cmp.sv]
`timescale 1ns / 1ps
// zksr_cmp: shared point-in-rectangle compare unit
// depends on zksr_pkg

module zksr_cmp (
    input  zksr_pkg::t_point i_point,
    input  zksr_pkg::t_rect  i_rect,
    output logic             o_inside
);

    zksr_pkg::t_coord w_rlo;
    zksr_pkg::t_coord w_rhi;
    zksr_pkg::t_coord w_clo;
    zksr_pkg::t_coord w_chi;

    always_comb begin
        w_rlo = (i_rect.ra < i_rect.rb) ? i_rect.ra : i_rect.rb;
        w_rhi = (i_rect.ra < i_rect.rb) ? i_rect.rb : i_rect.ra;
        w_clo = (i_rect.ca < i_rect.cb) ? i_rect.ca : i_rect.cb;
        w_chi = (i_rect.ca < i_rect.cb) ? i_rect.cb : i_rect.ca;
        o_inside = (i_point.row >= w_rlo) && (i_point.row <= w_rhi) &&
                   (i_point.col >= w_clo) && (i_point.col <= w_chi);
    end

endmodule

[sv/zone_keyed_store_with_routing_unit.sv]
`timescale 1ns / 1ps
// zone_keyed_store_with_routing_unit: top level of the 2-D zone keyed store node
// depends on zksr_pkg, zksr_ram, zksr_cmp

// One transaction in gives one transaction out. The node checks the point against its
// whole region and its owned zone, then routes it to the first neighbour zone that
// holds it, or adds, searches or deletes in a compacting store of STORE_DEPTH entries.
// Every check runs through a single rectangle compare unit, one rectangle or stored
// entry per cycle, so the cost is set by the scan of the store and neighbour rams:
// add neighbour writes its ram directly, points outside the region stop there, an
// owned add writes after the zone check, routing and search scan up to the first match,
// and delete finds the match and moves each later entry one place down. The next
// transaction is accepted as soon as the result is registered, while it waits at the
// output. There is no clearing pass after reset.

module zone_keyed_store_with_routing_unit #(
    parameter int STORE_DEPTH = zksr_pkg::STORE_DEPTH_DEF,
    parameter int PEER_DEPTH  = zksr_pkg::PEER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  zksr_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output zksr_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [zksr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [zksr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PAW = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
    localparam int SCW = $clog2(STORE_DEPTH + 1);
    localparam int PCW = $clog2(PEER_DEPTH + 1);
    localparam int IW  = ((SCW > PCW) ? SCW : PCW) + 1;

    zksr_pkg::t_state  r_state, n_state;
    zksr_pkg::t_in     r_in, n_in;
    logic [IW-1:0]     r_idx, n_idx;
    logic [SCW-1:0]    r_ecount, n_ecount;
    logic [PCW-1:0]    r_pcount, n_pcount;
    zksr_pkg::t_status r_status, n_status;
    logic              r_hit, n_hit;
    logic [zksr_pkg::WORD_W-1:0] r_rd, n_rd;
    logic [zksr_pkg::ID_W-1:0]   r_fwd, n_fwd;
    zksr_pkg::t_out    r_out, n_out;
    logic              r_out_valid, n_out_valid;
    zksr_pkg::t_rect   r_whole;
    zksr_pkg::t_rect   r_own;

    logic              w_st_we;
    logic [SAW-1:0]    w_st_waddr;
    zksr_pkg::t_entry  w_st_wdata;
    logic [SAW-1:0]    w_st_raddr;
    zksr_pkg::t_entry  w_st_rdata;
    logic              w_pe_we;
    logic [PAW-1:0]    w_pe_waddr;
    zksr_pkg::t_peer   w_pe_wdata;
    logic [PAW-1:0]    w_pe_raddr;
    zksr_pkg::t_peer   w_pe_rdata;

    zksr_pkg::t_point  w_point;
    zksr_pkg::t_rect   w_rect;
    logic              w_inside;
    logic [IW-1:0]     w_idx_inc;
    logic [IW-1:0]     w_idx_inc2;
    logic [IW-1:0]     w_ecount_ext;
    logic [IW-1:0]     w_pcount_ext;
    logic [SCW+4:0]    w_fill_ext;

    zksr_ram #(
        .WIDTH ($bits(zksr_pkg::t_entry)),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    zksr_ram #(
        .WIDTH ($bits(zksr_pkg::t_peer)),
        .DEPTH (PEER_DEPTH)
    ) u_peer_ram (
        .i_clk   (i_clk),
        .i_we    (w_pe_we),
        .i_waddr (w_pe_waddr),
        .i_wdata (w_pe_wdata),
        .i_raddr (w_pe_raddr),
        .o_rdata (w_pe_rdata)
    );

    zksr_cmp u_cmp (
        .i_point  (w_point),
        .i_rect   (w_rect),
        .o_inside (w_inside)
    );

    assign w_point      = '{row: r_in.point_row, col: r_in.point_col};
    assign w_idx_inc    = r_idx + IW'(1);
    assign w_idx_inc2   = r_idx + IW'(2);
    assign w_ecount_ext = IW'(r_ecount);
    assign w_pcount_ext = IW'(r_pcount);
    assign w_fill_ext   = (SCW + 5)'(r_ecount);

    // compare unit operand select
    always_comb begin
        case (r_state)
            zksr_pkg::S_WHOLE: w_rect = r_whole;
            zksr_pkg::S_OWN:   w_rect = r_own;
            zksr_pkg::S_PSCAN: w_rect = w_pe_rdata.zone;
            zksr_pkg::S_SSCAN: w_rect = '{ra: w_st_rdata.row, ca: w_st_rdata.col,
                                          rb: w_st_rdata.row, cb: w_st_rdata.col};
            default:           w_rect = r_whole;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zksr_pkg::S_IDLE;
            r_ecount    <= '0;
            r_pcount    <= '0;
            r_out_valid <= 1'b0;
            r_whole     <= '{ra: zksr_pkg::COORD_ZERO, ca: zksr_pkg::COORD_ZERO,
                             rb: zksr_pkg::COORD_FULL, cb: zksr_pkg::COORD_FULL};
            r_own       <= '{ra: zksr_pkg::COORD_ZERO, ca: zksr_pkg::COORD_ZERO,
                             rb: zksr_pkg::COORD_FULL, cb: zksr_pkg::COORD_FULL};
        end else begin
            r_state     <= n_state;
            r_ecount    <= n_ecount;
            r_pcount    <= n_pcount;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (zksr_pkg::t_cfg_idx'(i_cfg_index))
                    zksr_pkg::CFG_WHOLE_RA: r_whole.ra <= i_cfg_data;
                    zksr_pkg::CFG_WHOLE_CA: r_whole.ca <= i_cfg_data;
                    zksr_pkg::CFG_WHOLE_RB: r_whole.rb <= i_cfg_data;
                    zksr_pkg::CFG_WHOLE_CB: r_whole.cb <= i_cfg_data;
                    zksr_pkg::CFG_OWN_RA:   r_own.ra   <= i_cfg_data;
                    zksr_pkg::CFG_OWN_CA:   r_own.ca   <= i_cfg_data;
                    zksr_pkg::CFG_OWN_RB:   r_own.rb   <= i_cfg_data;
                    zksr_pkg::CFG_OWN_CB:   r_own.cb   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_hit    <= n_hit;
        r_rd     <= n_rd;
        r_fwd    <= n_fwd;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_idx       = r_idx;
        n_ecount    = r_ecount;
        n_pcount    = r_pcount;
        n_status    = r_status;
        n_hit       = r_hit;
        n_rd        = r_rd;
        n_fwd       = r_fwd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_st_we    = 1'b0;
        w_st_waddr = r_ecount[SAW-1:0];
        w_st_wdata = '{row: r_in.point_row, col: r_in.point_col, word: r_in.data_word};
        w_st_raddr = '0;
        w_pe_we    = 1'b0;
        w_pe_waddr = r_pcount[PAW-1:0];
        w_pe_wdata = '{id: r_in.peer_id,
                       zone: '{ra: r_in.peer_row_a, ca: r_in.peer_col_a,
                               rb: r_in.peer_row_b, cb: r_in.peer_col_b}};
        w_pe_raddr = '0;

        case (r_state)
            zksr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in     = i_in_data;
                    n_idx    = '0;
                    n_status = zksr_pkg::ST_LOCAL;
                    n_hit    = 1'b0;
                    n_rd     = '0;
                    n_fwd    = '0;
                    n_state  = (i_in_data.func == zksr_pkg::FN_ADD_PEER) ?
                               zksr_pkg::S_ADD_PEER : zksr_pkg::S_WHOLE;
                end
            end
            zksr_pkg::S_ADD_PEER: begin
                if (r_pcount < PCW'(PEER_DEPTH)) begin
                    w_pe_we  = 1'b1;
                    n_pcount = r_pcount + PCW'(1);
                    n_hit    = 1'b1;
                end
                n_state = zksr_pkg::S_DONE;
            end
            zksr_pkg::S_WHOLE: begin
                if (!w_inside) begin
                    n_status = zksr_pkg::ST_OUTSIDE;
                    n_state  = zksr_pkg::S_DONE;
                end else begin
                    n_state = zksr_pkg::S_OWN;
                end
            end
            zksr_pkg::S_OWN: begin
                if (!w_inside) begin
                    n_status = zksr_pkg::ST_NO_ROUTE;
                    n_state  = (r_pcount != '0) ? zksr_pkg::S_PSCAN : zksr_pkg::S_DONE;
                end else if (r_in.func == zksr_pkg::FN_ADD) begin
                    if (r_ecount < SCW'(STORE_DEPTH)) begin
                        w_st_we  = 1'b1;
                        n_ecount = r_ecount + SCW'(1);
                        n_hit    = 1'b1;
                    end
                    n_state = zksr_pkg::S_DONE;
                end else begin
                    n_state = (r_ecount != '0) ? zksr_pkg::S_SSCAN : zksr_pkg::S_DONE;
                end
            end
            zksr_pkg::S_PSCAN: begin
                if (w_inside) begin
                    n_status = zksr_pkg::ST_FORWARD;
                    n_fwd    = w_pe_rdata.id;
                    n_state  = zksr_pkg::S_DONE;
                end else if (w_idx_inc == w_pcount_ext) begin
                    n_state = zksr_pkg::S_DONE;
                end else begin
                    w_pe_raddr = w_idx_inc[PAW-1:0];
                    n_idx      = w_idx_inc;
                end
            end
            zksr_pkg::S_SSCAN: begin
                if (w_inside) begin
                    n_hit = 1'b1;
                    if (r_in.func == zksr_pkg::FN_SEARCH) begin
                        n_rd    = w_st_rdata.word;
                        n_state = zksr_pkg::S_DONE;
                    end else if (w_idx_inc == w_ecount_ext) begin
                        n_ecount = r_ecount - SCW'(1);
                        n_state  = zksr_pkg::S_DONE;
                    end else begin
                        w_st_raddr = w_idx_inc[SAW-1:0];
                        n_state    = zksr_pkg::S_SHIFT;
                    end
                end else if (w_idx_inc == w_ecount_ext) begin
                    n_state = zksr_pkg::S_DONE;
                end else begin
                    w_st_raddr = w_idx_inc[SAW-1:0];
                    n_idx      = w_idx_inc;
                end
            end
            zksr_pkg::S_SHIFT: begin
                // move the entry just read one place down
                w_st_we    = 1'b1;
                w_st_waddr = r_idx[SAW-1:0];
                w_st_wdata = w_st_rdata;
                if (w_idx_inc2 == w_ecount_ext) begin
                    n_ecount = r_ecount - SCW'(1);
                    n_state  = zksr_pkg::S_DONE;
                end else begin
                    w_st_raddr = w_idx_inc2[SAW-1:0];
                    n_idx      = w_idx_inc;
                end
            end
            zksr_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out = '{status:     r_status,
                              hit:        r_hit,
                              read_word:  r_rd,
                              forward_to: r_fwd,
                              fill_level: w_fill_ext[zksr_pkg::FILL_W-1:0]};
                    n_out_valid = 1'b1;
                    n_state     = zksr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = zksr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == zksr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= SCW'(STORE_DEPTH))
        else $error("store count above depth");

    a_peer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= PCW'(PEER_DEPTH))
        else $error("neighbour count above depth");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zksr_pkg::S_SHIFT) |-> (w_idx_inc < w_ecount_ext))
        else $error("shift beyond last entry");

    a_routed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != zksr_pkg::ST_LOCAL) |->
            (!r_out.hit && r_out.read_word == '0))
        else $error("routed or ignored transaction carries store result");

    a_fwd_only_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != zksr_pkg::ST_FORWARD) |->
            (r_out.forward_to == '0))
        else $error("neighbour id on a transaction not forwarded");

endmodule
